### rtl/blfcl_pkg.sv
// Package for the framed CRC link: field codes, queue entry type and the
// byte-wide CRC-16 update. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package blfcl_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  ACK_BYTE = 8'h30;

  // Input opcodes.
  localparam logic [1:0] OP_CMD     = 2'd0;
  localparam logic [1:0] OP_RESP    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_CRC_ERR    = 2'd1;
  localparam logic [1:0] ST_BAD_ACK    = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  // Register map.
  localparam logic REG_RESPONSE_LENGTH = 1'b0;

  // Queue between the classifier and the result sequencer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One classified item: up to three result beats.
  typedef struct packed {
    logic [1:0]  nres;    // beats in this entry, 1 to 3
    logic [1:0]  kind;
    logic [7:0]  byte0;   // first beat byte
    logic [15:0] crc;     // CRC bytes of a frame tail, or the status CRC
    logic [1:0]  status;
    logic [8:0]  count;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/blfcl_front.sv
// Front end: accepts input beats, keeps the send and receive CRC state and
// turns each item into at most one queue entry. Depends on blfcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blfcl_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        data,
  input  wire logic              last,
  input  wire logic [7:0]        response_length,
  input  wire logic              q_full,
  output logic                   full,
  output logic                   q_push,
  output blfcl_pkg::entry_t      q_entry
);
  import blfcl_pkg::*;

  logic [15:0] send_crc, send_crc_next;
  logic [15:0] recv_crc_calc, recv_crc_calc_next;
  logic [8:0]  recv_count, recv_count_next;
  logic [15:0] recv_crc_field, recv_crc_field_next;

  logic        accept;
  logic [15:0] crc_cmd;
  logic [15:0] crc_rsp;
  logic [8:0]  ack_pos;
  logic [8:0]  len_ext;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign crc_cmd = crc_byte(send_crc, data);
  assign crc_rsp = crc_byte(recv_crc_calc, data);
  assign len_ext = {1'b0, response_length};
  assign ack_pos = (response_length == 8'd0) ? 9'd0 : len_ext + 9'd2;

  always_comb begin
    send_crc_next       = send_crc;
    recv_crc_calc_next  = recv_crc_calc;
    recv_count_next     = recv_count;
    recv_crc_field_next = recv_crc_field;
    q_push              = 1'b0;
    q_entry             = '0;
    q_entry.nres        = 2'd1;
    if (accept) begin
      unique case (opcode)
        OP_CMD: begin
          q_push        = 1'b1;
          q_entry.kind  = KIND_TX;
          q_entry.byte0 = data;
          if (last) begin
            q_entry.nres  = 2'd3;
            q_entry.crc   = crc_cmd;
            send_crc_next = 16'h0000;
          end else begin
            send_crc_next = crc_cmd;
          end
        end
        OP_RESP: begin
          if (recv_count >= ack_pos) begin
            q_push         = 1'b1;
            q_entry.kind   = KIND_STATUS;
            q_entry.count  = recv_count + 9'd1;
            q_entry.crc    = recv_crc_calc;
            // A CRC mismatch outranks a bad ACK byte.
            if (response_length != 8'd0 && recv_crc_field != recv_crc_calc) begin
              q_entry.status = ST_CRC_ERR;
            end else if (data != ACK_BYTE) begin
              q_entry.status = ST_BAD_ACK;
            end else begin
              q_entry.status = ST_OK;
            end
            recv_crc_calc_next  = 16'h0000;
            recv_count_next     = 9'd0;
            recv_crc_field_next = 16'h0000;
          end else begin
            recv_count_next = recv_count + 9'd1;
            if (recv_count < len_ext) begin
              q_push             = 1'b1;
              q_entry.kind       = KIND_DATA;
              q_entry.byte0      = data;
              recv_crc_calc_next = crc_rsp;
            end else if (recv_count == len_ext) begin
              recv_crc_field_next = {recv_crc_field[15:8], data};
            end else begin
              recv_crc_field_next = {data, recv_crc_field[7:0]};
            end
          end
        end
        OP_TIMEOUT: begin
          q_push              = 1'b1;
          q_entry.kind        = KIND_STATUS;
          q_entry.status      = ST_INCOMPLETE;
          q_entry.count       = recv_count;
          q_entry.crc         = recv_crc_calc;
          recv_crc_calc_next  = 16'h0000;
          recv_count_next     = 9'd0;
          recv_crc_field_next = 16'h0000;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_crc       <= 16'h0000;
      recv_crc_calc  <= 16'h0000;
      recv_count     <= 9'd0;
      recv_crc_field <= 16'h0000;
    end else begin
      send_crc       <= send_crc_next;
      recv_crc_calc  <= recv_crc_calc_next;
      recv_count     <= recv_count_next;
      recv_crc_field <= recv_crc_field_next;
    end
  end

endmodule

`default_nettype wire

### rtl/blfcl_queue.sv
// Short entry queue between the front end and the result sequencer.
// Depends on blfcl_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module blfcl_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire blfcl_pkg::entry_t wr_entry,
  input  wire logic              rd_en,
  output blfcl_pkg::entry_t      rd_entry,
  output logic                   q_full,
  output logic                   q_empty
);
  import blfcl_pkg::*;

  entry_t                store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   fill;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full   = (fill == QUEUE_CW'(QUEUE_DEPTH));
  assign q_empty  = (fill == '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && !q_empty;
  assign rd_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + QUEUE_CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - QUEUE_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/blfcl_back.sv
// Result sequencer: steps through the beats of the queue head entry and
// retires the entry after its last beat is popped. Depends on blfcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blfcl_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire blfcl_pkg::entry_t head,
  input  wire logic              q_empty,
  input  wire logic              pop,
  output logic                   q_pop,
  output logic                   empty,
  output logic [1:0]             kind,
  output logic [7:0]             byte_out,
  output logic                   frame_end,
  output logic [1:0]             status,
  output logic [8:0]             received_count,
  output logic [15:0]            computed_crc
);
  import blfcl_pkg::*;

  logic [1:0] beat_idx;
  logic       is_status;
  logic       take;
  logic       last_beat;

  assign empty     = q_empty;
  assign take      = pop && !q_empty;
  assign last_beat = (beat_idx == head.nres - 2'd1);
  assign q_pop     = take && last_beat;
  assign is_status = (head.kind == KIND_STATUS);

  assign kind           = head.kind;
  assign frame_end      = (beat_idx == 2'd2);
  assign status         = is_status ? head.status : ST_OK;
  assign received_count = is_status ? head.count : 9'd0;
  assign computed_crc   = is_status ? head.crc : 16'h0000;

  always_comb begin
    case (beat_idx)
      2'd0:    byte_out = head.byte0;
      2'd1:    byte_out = head.crc[7:0];
      default: byte_out = head.crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx <= 2'd0;
    end else if (take) begin
      beat_idx <= last_beat ? 2'd0 : beat_idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

### rtl/bootloader_frame_crc_link_core.sv
// Top level of the framed command/response CRC link. Holds the register
// port and ties front end, queue and result sequencer; uses blfcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake          | Beat content
// ----------+--------------------+----------------------------------------------
// input     | push / full        | opcode, data, last
// result    | pop / empty        | kind, byte_out, frame_end, status,
//           |                    | received_count, computed_crc
// register  | psel/penable/pwrite| response_length at byte address 0
//
// The front end takes one input beat per cycle while the queue has room; the
// CRC update is unrolled so that each byte is classified in the cycle it lands.
// A command byte with last set yields three result beats, every other item at
// most one, and the result side delivers one beat per cycle while pop is held
// high, so the sustained rate is one item per cycle bar the extra frame-end beats.
// rst is synchronous and clears the CRC state, counters, queue and register.
// A stalled result side fills the four-entry queue and only then raises full.

module bootloader_frame_crc_link_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input queue side.
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  data,
  input  wire logic        last,
  // Result queue side.
  input  wire logic        pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [7:0]       byte_out,
  output logic             frame_end,
  output logic [1:0]       status,
  output logic [8:0]       received_count,
  output logic [15:0]      computed_crc,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import blfcl_pkg::*;

  logic   [7:0] response_length;
  logic         cfg_wr;
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  entry_t       q_wr_entry;
  entry_t       q_head;

  // The register port never waits. Only the word address bit decodes, so
  // unaligned byte addresses alias onto their word.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_length <= 8'd0;
    end else if (cfg_wr && (paddr[2] == REG_RESPONSE_LENGTH)) begin
      response_length <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_RESPONSE_LENGTH) ? {24'd0, response_length} : 32'd0;

  // Front end: classifies each item and updates both CRC directions.
  blfcl_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .opcode          (opcode),
    .data            (data),
    .last            (last),
    .response_length (response_length),
    .q_full          (q_full),
    .full            (full),
    .q_push          (q_push),
    .q_entry         (q_wr_entry)
  );

  // Decoupling queue: lets the result side stall without blocking input
  // until four entries wait.
  blfcl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .rd_en    (q_pop),
    .rd_entry (q_head),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  // Back end: walks the beats of the head entry.
  blfcl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .q_empty        (q_empty),
    .pop            (pop),
    .q_pop          (q_pop),
    .empty          (empty),
    .kind           (kind),
    .byte_out       (byte_out),
    .frame_end      (frame_end),
    .status         (status),
    .received_count (received_count),
    .computed_crc   (computed_crc)
  );

endmodule

`default_nettype wire

### verif/blfcl_link_checker.sv
// Scoreboard for the framed CRC link: watches the input, result and register
// channels, models the link state and compares every result beat.
// Depends on blfcl_pkg for the opcode, kind, status and register codes.
`timescale 1ns / 1ps

module blfcl_link_checker
  import blfcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data,
  input  logic        last,
  input  logic        pop,
  input  logic        empty,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_out,
  input  logic        frame_end,
  input  logic [1:0]  status,
  input  logic [8:0]  received_count,
  input  logic [15:0] computed_crc,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  octet;
    logic        fend;
    logic [1:0]  st;
    logic [8:0]  cnt;
    logic [15:0] crc;
  } beat_t;

  beat_t       expected_beats[$];
  int          mismatch_count = 0;

  // Link state as the block should hold it.
  logic [15:0] tx_crc;
  logic [15:0] rx_crc;
  logic [15:0] rx_crc_field;
  logic [8:0]  rx_count;
  logic [7:0]  resp_len;

  // Bit-serial form of the reflected CRC-16 update, one data bit per step.
  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return crc16_next_done(acc);
  endfunction

  function automatic logic [15:0] crc16_next_done(input logic [15:0] acc);
    return acc;
  endfunction

  function automatic beat_t make_beat(input logic [1:0] k, input logic [7:0] b,
                                      input logic fe, input logic [1:0] st,
                                      input logic [8:0] cnt, input logic [15:0] crc);
    beat_t r;
    r.kind  = k;
    r.octet = b;
    r.fend  = fe;
    r.st    = st;
    r.cnt   = cnt;
    r.crc   = crc;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic clear_rx();
    rx_crc       = '0;
    rx_crc_field = '0;
    rx_count     = '0;
  endtask

  // Works out the result beats that one accepted input beat causes.
  task automatic predict_item(input logic [1:0] op, input logic [7:0] value, input logic fin);
    logic [8:0] pos;
    logic [8:0] ack_pos;
    logic [1:0] verdict;
    case (op)
      OP_CMD: begin
        tx_crc = crc16_next(tx_crc, value);
        expected_beats.push_back(make_beat(KIND_TX, value, 1'b0, ST_OK, '0, '0));
        if (fin) begin
          expected_beats.push_back(make_beat(KIND_TX, tx_crc[7:0], 1'b0, ST_OK, '0, '0));
          expected_beats.push_back(make_beat(KIND_TX, tx_crc[15:8], 1'b1, ST_OK, '0, '0));
          tx_crc = '0;
        end
      end
      OP_RESP: begin
        pos     = rx_count;
        ack_pos = (resp_len == 8'd0) ? 9'd0 : {1'b0, resp_len} + 9'd2;
        if (pos >= ack_pos) begin
          // The CRC check takes precedence over the ACK check.
          if (resp_len != 8'd0 && rx_crc_field != rx_crc) begin
            verdict = ST_CRC_ERR;
          end else if (value != ACK_BYTE) begin
            verdict = ST_BAD_ACK;
          end else begin
            verdict = ST_OK;
          end
          expected_beats.push_back(make_beat(KIND_STATUS, 8'h00, 1'b0, verdict,
                                             pos + 9'd1, rx_crc));
          clear_rx();
        end else begin
          rx_count = pos + 9'd1;
          if (pos < {1'b0, resp_len}) begin
            rx_crc = crc16_next(rx_crc, value);
            expected_beats.push_back(make_beat(KIND_DATA, value, 1'b0, ST_OK, '0, '0));
          end else if (pos == {1'b0, resp_len}) begin
            rx_crc_field[7:0] = value;
          end else begin
            rx_crc_field[15:8] = value;
          end
        end
      end
      OP_TIMEOUT: begin
        expected_beats.push_back(make_beat(KIND_STATUS, 8'h00, 1'b0, ST_INCOMPLETE,
                                           rx_count, rx_crc));
        clear_rx();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    beat_t seen;
    beat_t want;
    if (rst) begin
      tx_crc   = '0;
      resp_len = '0;
      clear_rx();
      expected_beats.delete();
    end else begin
      if (psel && penable && pready && paddr == {REG_RESPONSE_LENGTH, 2'b00}) begin
        if (pwrite) begin
          resp_len = pwdata[7:0];
        end else if (prdata != {24'h0, resp_len}) begin
          report_mismatch("response_length read", prdata, {24'h0, resp_len});
        end
      end
      if (push && !full) begin
        predict_item(opcode, data, last);
      end
      if (pop && !empty) begin
        seen = make_beat(kind, byte_out, frame_end, status, received_count, computed_crc);
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing expected, kind", 32'(seen.kind), '0);
        end else begin
          want = expected_beats.pop_front();
          if (seen.kind != want.kind)
            report_mismatch("kind", 32'(seen.kind), 32'(want.kind));
          if (seen.octet != want.octet)
            report_mismatch("byte_out", 32'(seen.octet), 32'(want.octet));
          if (seen.fend != want.fend)
            report_mismatch("frame_end", 32'(seen.fend), 32'(want.fend));
          if (seen.st != want.st)
            report_mismatch("status", 32'(seen.st), 32'(want.st));
          if (seen.cnt != want.cnt)
            report_mismatch("received_count", 32'(seen.cnt), 32'(want.cnt));
          if (seen.crc != want.crc)
            report_mismatch("computed_crc", 32'(seen.crc), 32'(want.crc));
        end
      end
    end
    outstanding <= expected_beats.size();
    mismatches  <= mismatch_count;
  end

endmodule

### verif/tb_bootloader_frame_crc_link_core.sv
// Testbench top for the framed CRC link core: clock, reset, stimulus and the
// verdict. Depends on blfcl_pkg, blfcl_link_checker and the core itself.
`timescale 1ns / 1ps

module tb_bootloader_frame_crc_link_core;
  import blfcl_pkg::*;

  // Opcode 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Far above the slowest legal run: every item with three result beats, each
  // beat behind a long result stall and each item behind a long input gap.
  localparam int CYCLE_LIMIT = 400000;
  // Quiet cycles after the last expected beat before the link counts as idle.
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] RESP_LEN_ADDR = {REG_RESPONSE_LENGTH, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = OP_CMD;
  logic [7:0]  data = 8'h00;
  logic        last = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic        frame_end;
  logic [1:0]  status;
  logic [8:0]  received_count;
  logic [15:0] computed_crc;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int cycles = 0;
  // When set, the matching side runs without any idle cycles.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bootloader_frame_crc_link_core uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .opcode(opcode), .data(data), .last(last),
    .pop(pop), .empty(empty), .kind(kind), .byte_out(byte_out),
    .frame_end(frame_end), .status(status), .received_count(received_count),
    .computed_crc(computed_crc),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  blfcl_link_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .opcode(opcode), .data(data), .last(last),
    .pop(pop), .empty(empty), .kind(kind), .byte_out(byte_out),
    .frame_end(frame_end), .status(status), .received_count(received_count),
    .computed_crc(computed_crc),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Idle lengths for both sides: mostly none or a few cycles, now and then a
  // long stretch so that the queue fills and full is exercised.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 31);
    if (r == 0) begin
      return $urandom_range(12, 40);
    end else if (r < 12) begin
      return $urandom_range(1, 3);
    end
    return 0;
  endfunction

  // Result side: pop is redrawn every cycle, holding low through a stall.
  always @(posedge clk) begin : result_side
    int hold;
    int g;
    if (rst) begin
      pop  <= 1'b0;
      hold = 0;
    end else if (rx_steady) begin
      pop <= 1'b1;
    end else if (hold > 0) begin
      pop  <= 1'b0;
      hold = hold - 1;
    end else begin
      g = pick_gap();
      pop <= (g == 0);
      hold = (g > 0) ? g - 1 : 0;
    end
  end

  // Watchdog. A stuck handshake or a beat that never arrives ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one input beat and returns in the time step of its acceptance,
  // with push still high so that the next beat can follow back to back.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] value, input logic fin);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push   <= 1'b1;
    opcode <= op;
    data   <= value;
    last   <= fin;
    do @(posedge clk); while (full);
    if (op != OP_RESERVED) begin
      items_sent++;
    end
  endtask

  // Stops the sender and waits until every predicted beat has been taken.
  // The first edge lets the checker's count include the last accepted beat.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The register is only touched with the block idle; the read back is
  // checked by the scoreboard.
  task automatic set_response_length(input logic [7:0] len);
    drain_results();
    apb_access(1'b1, RESP_LEN_ADDR, {8'($urandom_range(0, 255)), 16'h0, len});
    apb_access(1'b0, RESP_LEN_ADDR, 32'h0);
  endtask

  // A command frame of n bytes, last set on the final one.
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) begin
      send_beat(OP_CMD, 8'($urandom_range(0, 255)), i == n - 1);
    end
  endtask

  // A complete response for the given length: data bytes, the CRC field low
  // byte first, then the ACK. Either part can be damaged on request. Now and
  // then a command byte slips in between, since the two directions must not
  // disturb each other. last is random on response beats; the block ignores it.
  task automatic send_response(input int len, input bit bad_crc, input bit bad_ack);
    logic [15:0] acc;
    logic [7:0]  b;
    acc = 16'h0000;
    for (int i = 0; i < len; i++) begin
      b   = 8'($urandom_range(0, 255));
      acc = crc_byte(acc, b);
      if ($urandom_range(0, 9) == 0) begin
        send_beat(OP_CMD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      send_beat(OP_RESP, b, 1'($urandom_range(0, 1)));
    end
    if (len != 0) begin
      if (bad_crc) begin
        acc = acc ^ (16'h0001 << $urandom_range(0, 15));
      end
      send_beat(OP_RESP, acc[7:0], 1'($urandom_range(0, 1)));
      send_beat(OP_RESP, acc[15:8], 1'($urandom_range(0, 1)));
    end
    send_beat(OP_RESP, bad_ack ? 8'($urandom_range(0, 255)) : ACK_BYTE,
              1'($urandom_range(0, 1)));
  endtask

  // Mostly frames and responses with random content, some responses damaged; the
  // rest is cut-off responses, stray timeouts, reserved opcodes and lone response bytes.
  task automatic random_traffic(input int goal, input int len);
    int cut;
    while (items_sent < goal) begin
      case ($urandom_range(0, 11))
        0, 1, 2: send_frame($urandom_range(1, 6));
        3, 4, 5, 6, 7: send_response(len, $urandom_range(0, 5) == 0,
                                     $urandom_range(0, 5) == 0);
        8: begin
          // Response cut short by a timeout before the ACK position.
          cut = (len == 0) ? 0 : $urandom_range(0, len + 1);
          for (int i = 0; i < cut; i++) begin
            send_beat(OP_RESP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          send_beat(OP_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        9: send_beat(OP_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        10: send_beat(OP_RESERVED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: send_beat(OP_RESP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    logic [7:0] len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, response length still at its reset value of zero.
    // A timeout with nothing received reports incomplete with a zero count.
    send_beat(OP_TIMEOUT, 8'h00, 1'b0);
    // Two-byte frame with the extreme byte values, then a one-byte frame.
    send_beat(OP_CMD, 8'h00, 1'b0);
    send_beat(OP_CMD, 8'hFF, 1'b1);
    send_beat(OP_CMD, 8'hA5, 1'b1);
    // ACK-only responses: a good ACK, then a wrong byte carrying a stray last.
    send_beat(OP_RESP, ACK_BYTE, 1'b0);
    send_beat(OP_RESP, 8'hFF, 1'b1);
    // The reserved opcode must vanish; a timeout ignores last as well.
    send_beat(OP_RESERVED, 8'hFF, 1'b1);
    send_beat(OP_TIMEOUT, 8'hFF, 1'b1);

    // Two data bytes: a clean response, one failing both checks (the CRC
    // error wins), and one with only a bad ACK.
    set_response_length(8'd2);
    send_response(2, 1'b0, 1'b0);
    send_response(2, 1'b1, 1'b1);
    send_response(2, 1'b0, 1'b1);
    // Timeout in the middle of a response.
    send_beat(OP_RESP, 8'h12, 1'b0);
    send_beat(OP_TIMEOUT, 8'h00, 1'b0);

    // Length shrinks while a response is half received: the next byte sits
    // at the new ACK position and must be judged as the ACK.
    set_response_length(8'd5);
    send_beat(OP_RESP, 8'h01, 1'b0);
    send_beat(OP_RESP, 8'h80, 1'b0);
    send_beat(OP_RESP, 8'h7F, 1'b0);
    set_response_length(8'd1);
    send_beat(OP_RESP, ACK_BYTE, 1'b0);

    // Random part over several lengths. Phase three runs both sides flat out;
    // each length change waits for the link to go quiet first.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 5: len = 8'd0;
        1: len = 8'd1;
        default: len = 8'($urandom_range(2, 6));
      endcase
      tx_steady = (ph == 3);
      rx_steady <= (ph == 3);
      set_response_length(len);
      random_traffic(items_sent + 3, len);
    end
    tx_steady = 1'b0;
    rx_steady <= 1'b0;

    // Longest response the register allows, so the received count reaches the
    // largest value it can take, 258, with a frame behind it.
    set_response_length(8'd255);
    send_response(255, 1'b0, 1'b0);
    send_frame(2);

    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
